/* rtl/core/plif_pkg.sv */
// Shared types and constants for the piecewise linear interpolator.
// No dependencies.
`default_nettype none
package plif_pkg;

    // item kinds
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_EVAL   = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_SAT   = 2'd3;

    // datapath widths
    localparam int DATA_W = 32;
    localparam int PROD_W = 64;
    localparam int ACC_W  = 66;
    localparam int NUM_W  = 65;
    localparam int DEN_W  = 33;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_FOUND,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_LOAD_1,
        ST_LOAD_A,
        ST_LOAD_B,
        ST_MUL,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } plif_state_t;

endpackage
`default_nettype wire

/* rtl/core/plif_div.sv */
// Bit-serial restoring divider of unsigned magnitudes, one quotient bit per cycle.
// Depends on plif_pkg for the operand widths.
`default_nettype none
module plif_div
    import plif_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic [NUM_W-1:0]      quotient
);

    localparam int BIT_W = $clog2(NUM_W);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(NUM_W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    // one restoring step
    always_comb begin
        rem_sh  = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
        fits    = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    // step sequencing
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        bit_next  = bit_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            bit_next  = LAST_BIT;
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? rem_sub : rem_sh;
            if (bit_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                bit_next = bit_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        bit_reg <= bit_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

/* rtl/core/piecewise_linear_interpolator_top.sv */
// Top level of the piecewise linear interpolator; uses plif_pkg and plif_div.
// Holds the breakpoint memories and the item sequencer.
`default_nettype none
// One item is taken at a time; s_ready is high only while the sequencer is idle.
// A clear, a rejected insert or an evaluate on an empty table goes from idle straight
// to the done state. An insert searches the table entry by entry for its slot, then
// shifts the entries above it up one slot each, each entry moving by a read and then
// a write of the memory. An evaluate searches for its segment, loads its end points,
// forms the four products on one shared 32x32 multiplier and divides in the
// bit-serial divider.
// The result waits in an output register, so the next item is taken as soon as
// the sequencer is free. The table has no reset; only entries below the point
// count are ever used.
module piecewise_linear_interpolator_top
    import plif_pkg::*;
#(
    parameter int MAX_POINTS = 16
)(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_kind,
    input  wire logic signed [DATA_W-1:0] s_point_x,
    input  wire logic signed [DATA_W-1:0] s_point_y,
    input  wire logic signed [DATA_W-1:0] s_sample,
    input  wire logic                     s_batch_end,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_mapped_value,
    output logic [1:0]                    m_status,
    output logic                          m_last_of_batch
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_POINTS);

    plif_state_t state_reg, state_next;

    logic [1:0]               kind_reg, kind_next;
    logic signed [DATA_W-1:0] px_reg, px_next;
    logic signed [DATA_W-1:0] py_reg, py_next;
    logic signed [DATA_W-1:0] smp_reg, smp_next;
    logic                     last_reg, last_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            k_reg, k_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic signed [DATA_W-1:0] x0_reg, x0_next, y0_reg, y0_next;
    logic signed [DATA_W-1:0] x1_reg, x1_next, y1_reg, y1_next;
    logic [1:0]               step_reg, step_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     neg_reg, neg_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [1:0]               st_reg, st_next;
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_val_reg, m_val_next;
    logic [1:0]               m_st_reg, m_st_next;
    logic                     m_last_reg, m_last_next;

    // breakpoint memories
    logic signed [DATA_W-1:0] x_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] y_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] rd_x_reg, rd_y_reg;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic signed [DATA_W-1:0] mem_wx, mem_wy;

    // shared multiplier operands and divider hookup
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [DEN_W-1:0]  dx;
    logic [DEN_W-1:0]         dx_mag;
    logic [ACC_W-1:0]         acc_mag;
    logic                     div_start, div_done;
    logic [NUM_W-1:0]         div_quo;
    logic                     over;
    logic [DATA_W-1:0]        q_lo;
    logic signed [DATA_W-1:0] key;
    logic                     accept, out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign key      = (kind_reg == KIND_INSERT) ? px_reg : smp_reg;

    always_comb begin
        mul_a = step_reg[1] ^ step_reg[0] ? y0_reg : y1_reg;
        mul_b = step_reg[1] ? (step_reg[0] ? x0_reg : x1_reg) : smp_reg;
        dx      = {x1_reg[DATA_W-1], x1_reg} - {x0_reg[DATA_W-1], x0_reg};
        dx_mag  = dx[DEN_W-1] ? DEN_W'(-dx) : DEN_W'(dx);
        acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        over    = |div_quo[NUM_W-1:DATA_W];
        q_lo    = div_quo[DATA_W-1:0];
    end

    plif_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_mag[NUM_W-1:0]),
        .divisor  (dx_mag),
        .done     (div_done),
        .quotient (div_quo)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_kind == KIND_INSERT && cnt_reg != FULL_CNT)
                        state_next = ST_SRCH_RD;
                    else if (s_kind == KIND_EVAL && cnt_reg != '0)
                        state_next = ST_SRCH_RD;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_SRCH_RD:   state_next = (k_reg == cnt_reg) ? ST_FOUND : ST_SRCH_CMP;
            ST_SRCH_CMP:  state_next = (key < rd_x_reg) ? ST_FOUND : ST_SRCH_RD;
            ST_FOUND: begin
                if (kind_reg == KIND_INSERT)
                    state_next = ST_SHIFT_RD;
                else if (cnt_reg == CW'(1))
                    state_next = ST_LOAD_1;
                else
                    state_next = ST_LOAD_A;
            end
            ST_SHIFT_RD:  state_next = (k_reg == idx_reg) ? ST_DONE : ST_SHIFT_WR;
            ST_SHIFT_WR:  state_next = ST_SHIFT_RD;
            ST_LOAD_1:    state_next = ST_DONE;
            ST_LOAD_A:    state_next = ST_LOAD_B;
            ST_LOAD_B:    state_next = (rd_x_reg == x0_reg) ? ST_DONE : ST_MUL;
            ST_MUL:       state_next = ST_ACC;
            ST_ACC:       state_next = (step_reg == 2'd3) ? ST_DIV_START : ST_MUL;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  state_next = div_done ? ST_DONE : ST_DIV_WAIT;
            ST_DONE:      state_next = out_free ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs of each state
    always_comb begin
        kind_next = kind_reg;  px_next = px_reg;  py_next = py_reg;
        smp_next = smp_reg;    last_next = last_reg;
        cnt_next = cnt_reg;    k_next = k_reg;    idx_next = idx_reg;
        x0_next = x0_reg;      y0_next = y0_reg;
        x1_next = x1_reg;      y1_next = y1_reg;
        step_next = step_reg;  prod_next = prod_reg;  acc_next = acc_reg;
        neg_next = neg_reg;    val_next = val_reg;    st_next = st_reg;
        m_valid_next = m_valid_reg;
        m_val_next = m_val_reg;  m_st_next = m_st_reg;  m_last_next = m_last_reg;
        mem_we = 1'b0;
        mem_waddr = k_reg[AW-1:0];
        mem_raddr = k_reg[AW-1:0];
        mem_wx = rd_x_reg;
        mem_wy = rd_y_reg;
        div_start = 1'b0;
        s_ready = (state_reg == ST_IDLE);

        if (m_valid_reg && m_ready)
            m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next = s_kind;  px_next = s_point_x;  py_next = s_point_y;
                    smp_next = s_sample; last_next = s_batch_end;
                    k_next = '0;
                    val_next = '0;
                    st_next = STAT_OK;
                    if (s_kind == KIND_CLEAR)
                        cnt_next = '0;
                    else if (s_kind == KIND_INSERT && cnt_reg == FULL_CNT)
                        st_next = STAT_FULL;
                    else if (s_kind == KIND_EVAL && cnt_reg == '0)
                        st_next = STAT_EMPTY;
                end
            end
            ST_SRCH_RD: begin
                if (k_reg == cnt_reg)
                    idx_next = cnt_reg;
            end
            ST_SRCH_CMP: begin
                if (key < rd_x_reg)
                    idx_next = k_reg;
                else
                    k_next = k_reg + 1'b1;
            end
            ST_FOUND: begin
                if (kind_reg == KIND_INSERT) begin
                    k_next = cnt_reg;
                end else if (cnt_reg == CW'(1)) begin
                    mem_raddr = '0;
                end else if (idx_reg == '0) begin
                    idx_next = CW'(1);
                    mem_raddr = '0;
                end else if (idx_reg == cnt_reg) begin
                    idx_next = cnt_reg - 1'b1;
                    mem_raddr = AW'(cnt_reg - CW'(2));
                end else begin
                    mem_raddr = AW'(idx_reg - 1'b1);
                end
            end
            ST_SHIFT_RD: begin
                if (k_reg == idx_reg) begin
                    mem_we = 1'b1;
                    mem_waddr = idx_reg[AW-1:0];
                    mem_wx = px_reg;
                    mem_wy = py_reg;
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    mem_raddr = AW'(k_reg - 1'b1);
                end
            end
            ST_SHIFT_WR: begin
                mem_we = 1'b1;
                k_next = k_reg - 1'b1;
            end
            ST_LOAD_1: val_next = rd_y_reg;
            ST_LOAD_A: begin
                x0_next = rd_x_reg;
                y0_next = rd_y_reg;
                mem_raddr = idx_reg[AW-1:0];
            end
            ST_LOAD_B: begin
                x1_next = rd_x_reg;
                y1_next = rd_y_reg;
                step_next = '0;
                acc_next = '0;
                if (rd_x_reg == x0_reg)
                    val_next = rd_y_reg;
            end
            ST_MUL: prod_next = mul_a * mul_b;
            ST_ACC: begin
                // odd steps subtract: y1*s - y0*s + y0*x1 - y1*x0
                if (step_reg[0])
                    acc_next = acc_reg - ACC_W'(prod_reg);
                else
                    acc_next = acc_reg + ACC_W'(prod_reg);
                step_next = step_reg + 1'b1;
            end
            ST_DIV_START: begin
                div_start = 1'b1;
                neg_next = acc_reg[ACC_W-1] ^ dx[DEN_W-1];
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (neg_reg) begin
                        if (over || q_lo > 32'h8000_0000) begin
                            val_next = 32'sh8000_0000;
                            st_next = STAT_SAT;
                        end else begin
                            val_next = -$signed(q_lo);
                        end
                    end else if (over || q_lo[DATA_W-1]) begin
                        val_next = 32'sh7FFF_FFFF;
                        st_next = STAT_SAT;
                    end else begin
                        val_next = $signed(q_lo);
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_val_next = val_reg;
                    m_st_next = st_reg;
                    m_last_next = last_reg;
                end
            end
            default: ;
        endcase
    end

    // table memories, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            x_mem[mem_waddr] <= mem_wx;
            y_mem[mem_waddr] <= mem_wy;
        end
        rd_x_reg <= x_mem[mem_raddr];
        rd_y_reg <= y_mem[mem_raddr];
    end

    // control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg <= kind_next;  px_reg <= px_next;  py_reg <= py_next;
        smp_reg <= smp_next;    last_reg <= last_next;
        k_reg <= k_next;        idx_reg <= idx_next;
        x0_reg <= x0_next;      y0_reg <= y0_next;
        x1_reg <= x1_next;      y1_reg <= y1_next;
        step_reg <= step_next;  prod_reg <= prod_next;  acc_reg <= acc_next;
        neg_reg <= neg_next;    val_reg <= val_next;    st_reg <= st_next;
        m_val_reg <= m_val_next;  m_st_reg <= m_st_next;  m_last_reg <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_mapped_value  = m_val_reg;
    assign m_status        = m_st_reg;
    assign m_last_of_batch = m_last_reg;

endmodule
`default_nettype wire

/* tb/sv/tb_piecewise_linear_interpolator_top.sv */
// Testbench for piecewise_linear_interpolator_top: directed table then random traffic.
// Depends on plif_pkg and the interpolator RTL; checks results against a built-in predictor.
`default_nettype none
module tb_piecewise_linear_interpolator_top;
    import plif_pkg::*;

    localparam int NPTS = 16;
    localparam int RAND_ITEMS = 1250;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] smp;
        logic        bend;
    } item_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
        logic        last;
    } res_t;

    // directed row: stimulus plus optional typed-in result
    typedef struct packed {
        item_t item;
        logic  has_exp;
        res_t  exp;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = KIND_CLEAR;
    logic signed [31:0] s_point_x = '0;
    logic signed [31:0] s_point_y = '0;
    logic signed [31:0] s_sample = '0;
    logic        s_batch_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_mapped_value;
    logic [1:0]  m_status;
    logic        m_last_of_batch;

    piecewise_linear_interpolator_top #(.MAX_POINTS(NPTS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_point_x(s_point_x), .s_point_y(s_point_y), .s_sample(s_sample),
        .s_batch_end(s_batch_end),
        .m_valid(m_valid), .m_ready(m_ready), .m_mapped_value(m_mapped_value),
        .m_status(m_status), .m_last_of_batch(m_last_of_batch)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // predictor state: sorted breakpoint table
    logic signed [31:0] tbl_x [NPTS];
    logic signed [31:0] tbl_y [NPTS];
    int   tbl_count = 0;
    res_t pending_results [$];
    int   errors = 0;
    int   n_results = 0;
    int   n_sat = 0;
    int   n_interp = 0;
    longint cycles = 0;
    logic stim_done = 1'b0;

    // exact segment evaluation with truncation toward zero and saturation
    function automatic void segment_value(input logic signed [31:0] x0, y0, x1, y1,
                                          input logic signed [31:0] s,
                                          output logic [31:0] val, output logic sat);
        logic signed [127:0] num;
        logic signed [127:0] den;
        logic signed [127:0] q;
        num = (128'(signed'(y1)) - 128'(signed'(y0))) * 128'(signed'(s))
            + 128'(signed'(y0)) * 128'(signed'(x1))
            - 128'(signed'(y1)) * 128'(signed'(x0));
        den = 128'(signed'(x1)) - 128'(signed'(x0));
        q = num / den;
        sat = 1'b0;
        if (q > 128'sd2147483647) begin
            sat = 1'b1;
            val = 32'h7fffffff;
        end else if (q < -128'sd2147483648) begin
            sat = 1'b1;
            val = 32'h80000000;
        end else begin
            val = q[31:0];
        end
    endfunction

    // apply one item to the table and return its result
    function automatic res_t map_item(input item_t it);
        res_t r;
        int slot;
        int idx;
        logic sat;
        r.value = '0;
        r.status = STAT_OK;
        r.last = it.bend;
        case (it.kind)
            KIND_CLEAR: begin
                tbl_count = 0;
            end
            KIND_INSERT: begin
                if (tbl_count >= NPTS) begin
                    r.status = STAT_FULL;
                end else begin
                    slot = tbl_count;
                    for (int k = tbl_count - 1; k >= 0; k--)
                        if ($signed(it.px) < tbl_x[k]) slot = k;
                    for (int k = tbl_count; k > slot; k--) begin
                        tbl_x[k] = tbl_x[k-1];
                        tbl_y[k] = tbl_y[k-1];
                    end
                    tbl_x[slot] = it.px;
                    tbl_y[slot] = it.py;
                    tbl_count++;
                end
            end
            KIND_EVAL: begin
                if (tbl_count == 0) begin
                    r.status = STAT_EMPTY;
                end else if (tbl_count == 1) begin
                    r.value = tbl_y[0];
                end else begin
                    idx = tbl_count;
                    for (int k = tbl_count - 1; k >= 0; k--)
                        if ($signed(it.smp) < tbl_x[k]) idx = k;
                    if (idx == 0) idx = 1;
                    if (idx == tbl_count) idx = tbl_count - 1;
                    if (tbl_x[idx] == tbl_x[idx-1]) begin
                        r.value = tbl_y[idx];
                    end else begin
                        segment_value(tbl_x[idx-1], tbl_y[idx-1], tbl_x[idx], tbl_y[idx],
                                      it.smp, r.value, sat);
                        n_interp++;
                        if (sat) begin
                            r.status = STAT_SAT;
                            n_sat++;
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // short random gap: mostly none or short, sometimes long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // drive one transfer on the input channel
    task automatic send_item(input item_t it);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= it.kind;
        s_point_x   <= it.px;
        s_point_y   <= it.py;
        s_sample    <= it.smp;
        s_batch_end <= it.bend;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(map_item(it));
    endtask

    function automatic item_t mk(input logic [1:0] k, input logic [31:0] x, y, s,
                                 input logic b);
        item_t it;
        it.kind = k;
        it.px = x;
        it.py = y;
        it.smp = s;
        it.bend = b;
        return it;
    endfunction

    // random 32-bit value, biased toward edges and small magnitudes
    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff - $urandom_range(0, 3);
            1: return 32'h80000000 + $urandom_range(0, 3);
            2, 3: return 32'($signed($urandom_range(0, 2 * 65536 * 40)) - 65536 * 40);
            default: return $urandom;
        endcase
    endfunction

    // result channel: random stall and field check
    initial begin
        res_t want;
        int g;
        @(posedge aclk);
        forever begin
            g = gap_len();
            if ($urandom_range(0, 3) == 0) g = 0;
            m_ready <= (g == 0);
            if (g != 0) begin
                repeat (g) @(posedge aclk);
                m_ready <= 1'b1;
            end
            do @(posedge aclk); while (!(m_valid && m_ready));
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_mapped_value !== want.value) begin
                    $error("mapped_value expected %h actual %h", want.value, m_mapped_value);
                    errors++;
                end
                if (m_status !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, m_status);
                    errors++;
                end
                if (m_last_of_batch !== want.last) begin
                    $error("last_of_batch expected %0d actual %0d", want.last,
                           m_last_of_batch);
                    errors++;
                end
            end
        end
    end

    // directed table check: compares typed-in results against the predictor queue
    task automatic run_directed();
        row_t rows [$];
        res_t none;
        none = '0;
        rows.push_back('{mk(KIND_EVAL, 0, 0, 0, 1), 1'b1, '{32'd0, STAT_EMPTY, 1'b1}});
        rows.push_back('{mk(2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0), 1'b1,
                         '{32'd0, STAT_OK, 1'b0}});
        rows.push_back('{mk(KIND_INSERT, 32'h00010000, 32'h00050000, 0, 0), 1'b1, none});
        rows.push_back('{mk(KIND_EVAL, 0, 0, 32'h80000000, 1), 1'b1,
                         '{32'h00050000, STAT_OK, 1'b1}});
        rows.push_back('{mk(KIND_INSERT, 32'h00030000, 32'h00090000, 0, 0), 1'b1, none});
        rows.push_back('{mk(KIND_EVAL, 0, 0, 32'h00020000, 0), 1'b1,
                         '{32'h00070000, STAT_OK, 1'b0}});
        rows.push_back('{mk(KIND_EVAL, 0, 0, 32'h7fffffff, 0), 1'b1,
                         '{32'h7fffffff, STAT_SAT, 1'b0}});
        rows.push_back('{mk(KIND_EVAL, 0, 0, 32'h80000000, 0), 1'b1,
                         '{32'h80000000, STAT_SAT, 1'b0}});
        rows.push_back('{mk(KIND_EVAL, 0, 0, 32'h00000001, 0), 1'b0, none});
        rows.push_back('{mk(KIND_INSERT, 32'h00030000, 32'h80000000, 0, 1), 1'b1,
                         '{32'd0, STAT_OK, 1'b1}});
        rows.push_back('{mk(KIND_EVAL, 0, 0, 32'h00050000, 0), 1'b1,
                         '{32'h80000000, STAT_OK, 1'b0}});
        rows.push_back('{mk(KIND_INSERT, 32'h80000000, 32'h7fffffff, 0, 0), 1'b1, none});
        rows.push_back('{mk(KIND_INSERT, 32'h7fffffff, 32'h80000000, 0, 0), 1'b1, none});
        rows.push_back('{mk(KIND_EVAL, 0, 0, 32'hfffffffe, 0), 1'b0, none});
        rows.push_back('{mk(KIND_EVAL, 0, 0, 32'h7ffffffe, 0), 1'b0, none});
        for (int k = 0; k < 11; k++)
            rows.push_back('{mk(KIND_INSERT, $urandom, $urandom, 0, 0), 1'b0, none});
        rows.push_back('{mk(KIND_INSERT, 0, 0, 0, 1), 1'b1, '{32'd0, STAT_FULL, 1'b1}});
        rows.push_back('{mk(KIND_CLEAR, 32'hffffffff, 0, 32'hffffffff, 1), 1'b1,
                         '{32'd0, STAT_OK, 1'b1}});
        foreach (rows[i]) begin
            send_item(rows[i].item);
            if (rows[i].has_exp && pending_results[$] !== rows[i].exp) begin
                $error("row %0d predicted %h typed %h", i, pending_results[$], rows[i].exp);
                errors++;
            end
        end
    endtask

    // random phases: fill a table, then evaluate against it, with some noise
    task automatic run_random();
        int sent;
        int npts;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            send_item(mk(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom_range(0, 1)));
            sent++;
            npts = ($urandom_range(0, 9) == 0) ? $urandom_range(NPTS, NPTS + 2)
                                                : $urandom_range(0, 6);
            for (int k = 0; k < npts; k++) begin
                // duplicate abscissae now and then
                if (tbl_count > 0 && $urandom_range(0, 5) == 0)
                    send_item(mk(KIND_INSERT, tbl_x[$urandom_range(0, tbl_count - 1)],
                                 rnd_val(), $urandom, $urandom_range(0, 1)));
                else
                    send_item(mk(KIND_INSERT, rnd_val(), rnd_val(), $urandom,
                                 $urandom_range(0, 1)));
                sent++;
            end
            for (int k = $urandom_range(1, 10); k > 0; k--) begin
                if ($urandom_range(0, 15) == 0)
                    send_item(mk(2'd3, $urandom, $urandom, $urandom, $urandom_range(0, 1)));
                else if (tbl_count > 0 && $urandom_range(0, 2) == 0)
                    send_item(mk(KIND_EVAL, $urandom, $urandom,
                                 tbl_x[$urandom_range(0, tbl_count - 1)],
                                 $urandom_range(0, 1)));
                else
                    send_item(mk(KIND_EVAL, $urandom, $urandom, rnd_val(),
                                 $urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_random();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        stim_done = 1'b1;
    end

    // cycle limit and final verdict
    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (stim_done) begin
                $display("covered %0d results, %0d segment evaluations, %0d saturated",
                         n_results, n_interp, n_sat);
                if (errors == 0)
                    $display("Verification passed");
                else
                    $display("Verification failed");
                $finish;
            end else if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire
